// ===== rtl/ese_pkg.sv =====
// ese_pkg: shared constants and the controller-to-datapath command type
// for the exchange sort engine. No dependencies.
`timescale 1ns / 1ps

package ese_pkg;

  // store geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic              key_load;   // capture value_in as insertion key
    logic              rd_en;      // read store into the read register
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;      // write store
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_key;     // write data: key (1) or read register (0)
    logic              emit;       // read register becomes a result next cycle
    logic              emit_last;  // that result closes the run
  } ese_cmd_t;

endpackage

// ===== rtl/ese_datapath.sv =====
// ese_datapath: element store memory, insertion key, signed compare and
// result registers. Depends on ese_pkg; driven by ese_controller.
`timescale 1ns / 1ps

module ese_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ese_pkg::ese_cmd_t                 cmd,
  input  logic signed [ese_pkg::DATA_W-1:0] value_in,
  output logic                              key_less,
  output logic signed [ese_pkg::DATA_W-1:0] value_out,
  output logic                              last_out,
  output logic                              result_valid
);

  logic signed [ese_pkg::DATA_W-1:0] mem [ese_pkg::DEPTH];
  logic signed [ese_pkg::DATA_W-1:0] key;
  logic signed [ese_pkg::DATA_W-1:0] rd_data;
  logic                              res_valid;
  logic                              res_last;

  // insertion key register
  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key <= value_in;
    end
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_key ? key : rd_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  // key belongs below the element just read
  assign key_less = key < rd_data;

  // result strobe comes in the cycle after the emit read
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_last  <= 1'b0;
    end else begin
      res_valid <= cmd.emit;
      res_last  <= cmd.emit_last;
    end
  end

  assign value_out    = rd_data;
  assign last_out     = res_valid & res_last;
  assign result_valid = res_valid;

endmodule

// ===== rtl/ese_controller.sv =====
// ese_controller: state machine that keeps the store sorted on load by
// insertion and sweeps it out on a last request. Depends on ese_pkg.
`timescale 1ns / 1ps

module ese_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              is_last,
  input  logic              key_less,
  output logic              busy,
  output ese_pkg::ese_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                 state, state_next;
  logic [ese_pkg::CNT_W-1:0]  count, count_next;
  logic [ese_pkg::ADDR_W-1:0] k, k_next;
  logic [ese_pkg::ADDR_W-1:0] e, e_next;
  logic                       last_pend, last_pend_next;
  logic [ese_pkg::ADDR_W-1:0] e_final;

  // index of the final stored element
  assign e_final = ese_pkg::ADDR_W'(count - ese_pkg::CNT_W'(1));

  // next state and commands
  always_comb begin
    state_next     = state;
    count_next     = count;
    k_next         = k;
    e_next         = e;
    last_pend_next = last_pend;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.key_load   = 1'b1;
          last_pend_next = is_last;
          if (count < ese_pkg::CNT_W'(ese_pkg::DEPTH)) begin
            count_next = count + ese_pkg::CNT_W'(1);
            k_next     = count[ese_pkg::ADDR_W-1:0];
            state_next = ST_INS;
          end else if (is_last) begin
            e_next     = '0;
            state_next = ST_EMIT;
          end
        end
      end
      ST_INS: begin
        if (k == '0) begin
          // key lands at the bottom of the store
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = '0;
          cmd.wr_key  = 1'b1;
          e_next      = '0;
          state_next  = last_pend ? ST_EMIT : ST_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = k - ese_pkg::ADDR_W'(1);
          state_next  = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = k;
        if (key_less) begin
          // shift the larger element up one slot
          cmd.wr_key = 1'b0;
          k_next     = k - ese_pkg::ADDR_W'(1);
          state_next = ST_INS;
        end else begin
          cmd.wr_key = 1'b1;
          e_next     = '0;
          state_next = last_pend ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = e;
        cmd.emit    = 1'b1;
        if (e == e_final) begin
          cmd.emit_last = 1'b1;
          count_next    = '0;
          state_next    = ST_IDLE;
        end else begin
          e_next = e + ese_pkg::ADDR_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      last_pend <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      last_pend <= last_pend_next;
    end
  end

  // index registers
  always_ff @(posedge clk) begin
    k <= k_next;
    e <= e_next;
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/exchange_sort_engine.sv =====
// exchange_sort_engine: top level, joins ese_controller and ese_datapath.
// Depends on ese_pkg, ese_controller, ese_datapath.
`timescale 1ns / 1ps
//
//  channel   handshake                 payload
//  --------  ------------------------  ------------------------
//  request   start && !busy            value_in, is_last
//  result    result_valid (1 cycle)    value_out, last_out
//
// A request with a free slot inserts its value: each larger element is read and
// shifted up one slot, then the key is written into the freed slot or slot 0.
// A last request then emits count results, one per cycle, each read from the
// store in the emit state and registered before it is shown.
// A request on a full store is dropped, a last one still emits; synchronous
// rst clears control state only. Results cannot be stalled: one cycle each.

module exchange_sort_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ese_pkg::DATA_W-1:0] value_in,
  input  logic                              is_last,
  output logic                              result_valid,
  output logic signed [ese_pkg::DATA_W-1:0] value_out,
  output logic                              last_out
);

  ese_pkg::ese_cmd_t cmd;
  logic              key_less;

  // sequencing
  ese_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .is_last  (is_last),
    .key_less (key_less),
    .busy     (busy),
    .cmd      (cmd)
  );

  // store and results
  ese_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value_in     (value_in),
    .key_less     (key_less),
    .value_out    (value_out),
    .last_out     (last_out),
    .result_valid (result_valid)
  );

endmodule

// ===== rtl/ese_checker.sv =====
// ese_checker: port-level assertions for exchange_sort_engine, attached
// by the bind below. Depends on exchange_sort_engine's ports only.
`timescale 1ns / 1ps

module ese_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic is_last,
  input logic result_valid,
  input logic last_out
);

  // a last request always starts work
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_last) |=> busy)
    else $error("last request did not raise busy");

  // the closing flag only rides on a result
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last_out |-> result_valid)
    else $error("last_out without result_valid");

  // nothing follows the closing result directly
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    last_out |=> !result_valid)
    else $error("result right after closing result");

  // once idle, only the closing result may still appear
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !busy) |-> last_out)
    else $error("non-final result while idle");

  // reset leaves the block idle and quiet
  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("busy or result after reset");

endmodule

bind exchange_sort_engine ese_checker u_ese_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .is_last      (is_last),
  .result_valid (result_valid),
  .last_out     (last_out)
);
